// File: rtl/lzd_pkg.sv
// shared types and constants for the lz77 line decoder
package lzd_pkg;

    // default sizes
    localparam int HISTORY_BYTES_DEF    = 8192;
    localparam int BYTES_PER_RESULT_DEF = 8;

    // stream format constants
    localparam logic [4:0]  LOW5_MASK  = 5'h1F;
    localparam logic [2:0]  TOP_LIT    = 3'd0;
    localparam logic [2:0]  TOP_LONG   = 3'd7;
    localparam logic [8:0]  LEN_BIAS   = 9'd2;
    localparam logic [13:0] WPOS_MAX   = 14'd16383;

    // decode phase of the compressed stream
    typedef enum logic [2:0] {
        PH_FIRST_HEADER = 3'd0,
        PH_HEADER       = 3'd1,
        PH_LITERAL      = 3'd2,
        PH_SHORT_OFFSET = 3'd3,
        PH_LONG_LENGTH  = 3'd4,
        PH_LONG_OFFSET  = 3'd5
    } phase_t;

    // sequencer state
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_LIT  = 2'd1,
        ST_ADDR = 2'd2,
        ST_COPY = 2'd3
    } state_t;

    // one decoded byte handed to the packer
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
        logic       eol;
        logic       bad;
    } pk_push_t;

endpackage

// File: rtl/lzd_history.sv
// line history memory with registered read and write-to-read forwarding
module lzd_history
    import lzd_pkg::*;
#(
    parameter int HISTORY_BYTES = HISTORY_BYTES_DEF,
    localparam int AW = $clog2(HISTORY_BYTES)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [HISTORY_BYTES];
    logic [7:0] q_reg;
    logic [7:0] fwd_data_reg;
    logic       fwd_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            q_reg        <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // forward a byte written in the same cycle as its read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : q_reg;

endmodule

// File: rtl/lzd_packer.sv
// packs decoded bytes into result words with an output register
module lzd_packer
    import lzd_pkg::*;
#(
    parameter int BYTES_PER_RESULT = BYTES_PER_RESULT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  pk_push_t    push,
    output logic        push_ready,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] out_bytes,
    output logic [3:0]  byte_count,
    output logic        run_last,
    output logic        line_done,
    output logic        bad_reference
);

    localparam logic [2:0] CNT_TOP = 3'(BYTES_PER_RESULT - 1);

    logic [63:0] acc_reg, acc_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        ov_reg, ov_next;
    logic [63:0] word_reg, word_next;
    logic [3:0]  bc_reg, bc_next;
    logic        last_reg, last_next;
    logic        done_reg, done_next;
    logic        bad_reg, bad_next;
    logic        slot_free;
    logic        closes;
    logic [63:0] merged;

    // accumulate and hand full words, or the last bytes of a run, to the output register
    always_comb
    begin
        slot_free  = !ov_reg || !out_stall;
        closes     = push.last || (cnt_reg == CNT_TOP);
        push_ready = slot_free || !closes;

        merged = acc_reg;
        merged[8*cnt_reg +: 8] = push.data;

        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        ov_next   = ov_reg && out_stall;
        word_next = word_reg;
        bc_next   = bc_reg;
        last_next = last_reg;
        done_next = done_reg;
        bad_next  = bad_reg;

        if (push.valid && push_ready)
        begin
            if (closes)
            begin
                ov_next   = 1'b1;
                word_next = merged;
                bc_next   = 4'(cnt_reg) + 4'd1;
                last_next = push.last;
                done_next = push.last && push.eol;
                bad_next  = push.bad;
                acc_next  = '0;
                cnt_next  = '0;
            end
            else
            begin
                acc_next = merged;
                cnt_next = cnt_reg + 3'd1;
            end
        end
    end

    // control and accumulator registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            ov_reg  <= ov_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        bc_reg   <= bc_next;
        last_reg <= last_next;
        done_reg <= done_next;
        bad_reg  <= bad_next;
    end

    assign out_valid     = ov_reg;
    assign out_bytes     = word_reg;
    assign byte_count    = bc_reg;
    assign run_last      = last_reg;
    assign line_done     = done_reg;
    assign bad_reference = bad_reg;

endmodule

// File: rtl/lz77_line_decoder.sv
// top level of the lz77 line decoder: stream sequencer, history and packer
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------------------
//  input   | in_valid  | in_stall  | in_byte, end_of_line
//  output  | out_valid | out_stall | out_bytes, byte_count, run_last,
//          |           |           | line_done, bad_reference
//
// header and length bytes are taken in the idle state, a literal byte also passes the literal state
// a match offset byte passes the address and copy states: one history byte per cycle
// through the single read port of the history memory, while the packer accepts bytes
// the history is not cleared; a match that reaches before line start reads zeros
// reset clears the sequencer, write position and output valid flag
// out_stall holds the output word and pauses the copy at the next word boundary or run end
module lz77_line_decoder
    import lzd_pkg::*;
#(
    parameter int HISTORY_BYTES    = HISTORY_BYTES_DEF,
    parameter int BYTES_PER_RESULT = BYTES_PER_RESULT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        end_of_line,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] out_bytes,
    output logic [3:0]  byte_count,
    output logic        run_last,
    output logic        line_done,
    output logic        bad_reference
);

    localparam int AW = $clog2(HISTORY_BYTES);
    localparam logic [16:0]   HIST_SIZE = 17'(HISTORY_BYTES);
    localparam logic [AW-1:0] ADDR_TOP  = AW'(HISTORY_BYTES - 1);

    state_t        state_reg, state_next;
    phase_t        phase_reg, phase_next;
    logic [5:0]    lit_left_reg, lit_left_next;
    logic [8:0]    mlen_reg, mlen_next;
    logic [12:0]   moff_reg, moff_next;
    logic          eol_reg, eol_next;
    logic [7:0]    byte_reg, byte_next;
    logic [AW-1:0] ring_reg, ring_next;
    logic [13:0]   wpos_reg, wpos_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic [8:0]    rd_left_reg, rd_left_next;
    logic [8:0]    wr_left_reg, wr_left_next;
    logic          b_valid_reg, b_valid_next;
    logic          bad_reg, bad_next;

    logic          restart;
    logic          hist_we;
    logic [7:0]    hist_wdata;
    logic          hist_re;
    logic [7:0]    hist_rdata;
    logic [7:0]    copy_byte;
    logic          pk_ready;
    pk_push_t      push;
    logic [2:0]    top;
    logic [13:0]   copy_dist;
    logic [16:0]   dist_ext;
    logic [16:0]   ring_ext;
    logic [16:0]   start_ext;
    logic          issue;
    logic          take;

    // history memory
    lzd_history #(
        .HISTORY_BYTES(HISTORY_BYTES)
    ) u_history (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (hist_we),
        .wr_addr (ring_reg),
        .wr_data (hist_wdata),
        .rd_en   (hist_re),
        .rd_addr (rd_addr_reg),
        .rd_data (hist_rdata)
    );

    // result packer
    lzd_packer #(
        .BYTES_PER_RESULT(BYTES_PER_RESULT)
    ) u_packer (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .push_ready    (pk_ready),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_bytes     (out_bytes),
        .byte_count    (byte_count),
        .run_last      (run_last),
        .line_done     (line_done),
        .bad_reference (bad_reference)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign top       = in_byte[7:5];
    assign copy_byte = bad_reg ? 8'd0 : hist_rdata;

    // match distance and copy start, from a compare and a subtract that wraps around the history
    always_comb
    begin
        copy_dist = 14'(moff_reg) + 14'd1;
        dist_ext  = 17'(copy_dist);
        ring_ext  = 17'(ring_reg);
        if (ring_ext >= dist_ext)
        begin
            start_ext = ring_ext - dist_ext;
        end
        else
        begin
            start_ext = ring_ext + HIST_SIZE - dist_ext;
        end
    end

    // sequencer next state and outputs
    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        lit_left_next = lit_left_reg;
        mlen_next     = mlen_reg;
        moff_next     = moff_reg;
        eol_next      = eol_reg;
        byte_next     = byte_reg;
        ring_next     = ring_reg;
        wpos_next     = wpos_reg;
        rd_addr_next  = rd_addr_reg;
        rd_left_next  = rd_left_reg;
        wr_left_next  = wr_left_reg;
        b_valid_next  = b_valid_reg;
        bad_next      = bad_reg;
        restart       = 1'b0;
        hist_we       = 1'b0;
        hist_wdata    = copy_byte;
        hist_re       = 1'b0;
        push          = '0;
        issue         = 1'b0;
        take          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    eol_next  = end_of_line;
                    byte_next = in_byte;
                    case (phase_reg)
                        PH_FIRST_HEADER:
                        begin
                            lit_left_next = 6'(in_byte[4:0] & LOW5_MASK) + 6'd1;
                            phase_next    = PH_LITERAL;
                        end
                        PH_HEADER:
                        begin
                            if (top == TOP_LIT)
                            begin
                                lit_left_next = 6'(in_byte[4:0] & LOW5_MASK) + 6'd1;
                                phase_next    = PH_LITERAL;
                            end
                            else if (top == TOP_LONG)
                            begin
                                moff_next  = 13'(in_byte[4:0] & LOW5_MASK);
                                phase_next = PH_LONG_LENGTH;
                            end
                            else
                            begin
                                moff_next  = 13'(in_byte[4:0] & LOW5_MASK);
                                mlen_next  = 9'(top) + LEN_BIAS;
                                phase_next = PH_SHORT_OFFSET;
                            end
                        end
                        PH_LITERAL:
                        begin
                            state_next = ST_LIT;
                            if (lit_left_reg != 6'd0)
                            begin
                                lit_left_next = lit_left_reg - 6'd1;
                            end
                            if (lit_left_reg <= 6'd1)
                            begin
                                phase_next = PH_HEADER;
                            end
                        end
                        PH_LONG_LENGTH:
                        begin
                            mlen_next  = 9'(in_byte) + 9'(TOP_LONG) + LEN_BIAS;
                            phase_next = PH_LONG_OFFSET;
                        end
                        PH_SHORT_OFFSET, PH_LONG_OFFSET:
                        begin
                            moff_next  = {moff_reg[4:0] & LOW5_MASK, in_byte};
                            state_next = ST_ADDR;
                            phase_next = PH_HEADER;
                        end
                        default:
                        begin
                            phase_next = PH_HEADER;
                        end
                    endcase
                    if (end_of_line && (state_next == ST_IDLE))
                    begin
                        restart = 1'b1;
                    end
                end
            end

            ST_LIT:
            begin
                push.valid = 1'b1;
                push.data  = byte_reg;
                push.last  = 1'b1;
                push.eol   = eol_reg;
                push.bad   = 1'b0;
                hist_wdata = byte_reg;
                if (pk_ready)
                begin
                    take       = 1'b1;
                    state_next = ST_IDLE;
                    restart    = eol_reg;
                end
            end

            ST_ADDR:
            begin
                bad_next     = (dist_ext > 17'(wpos_reg)) || (dist_ext > HIST_SIZE);
                rd_addr_next = AW'(start_ext);
                rd_left_next = mlen_reg;
                wr_left_next = mlen_reg;
                b_valid_next = 1'b0;
                state_next   = ST_COPY;
            end

            ST_COPY:
            begin
                push.valid = b_valid_reg;
                push.data  = copy_byte;
                push.last  = (wr_left_reg == 9'd1);
                push.eol   = eol_reg;
                push.bad   = bad_reg;
                take       = b_valid_reg && pk_ready;
                issue      = (rd_left_reg != 9'd0) && (!b_valid_reg || take);
                hist_re    = issue;
                if (issue)
                begin
                    rd_addr_next = (rd_addr_reg == ADDR_TOP) ? '0 : rd_addr_reg + 1'b1;
                    rd_left_next = rd_left_reg - 9'd1;
                    b_valid_next = 1'b1;
                end
                else if (take)
                begin
                    b_valid_next = 1'b0;
                end
                if (take)
                begin
                    wr_left_next = wr_left_reg - 9'd1;
                    if (wr_left_reg == 9'd1)
                    begin
                        mlen_next  = '0;
                        state_next = ST_IDLE;
                        restart    = eol_reg;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // history write of each delivered byte
        if (take)
        begin
            hist_we   = 1'b1;
            ring_next = (ring_reg == ADDR_TOP) ? '0 : ring_reg + 1'b1;
            if (wpos_reg != WPOS_MAX)
            begin
                wpos_next = wpos_reg + 14'd1;
            end
        end

        // new line after the end-of-line byte
        if (restart)
        begin
            ring_next     = '0;
            wpos_next     = '0;
            phase_next    = PH_FIRST_HEADER;
            lit_left_next = '0;
            mlen_next     = '0;
            moff_next     = '0;
        end
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_FIRST_HEADER;
            lit_left_reg <= '0;
            mlen_reg     <= '0;
            moff_reg     <= '0;
            eol_reg      <= 1'b0;
            ring_reg     <= '0;
            wpos_reg     <= '0;
            rd_left_reg  <= '0;
            wr_left_reg  <= '0;
            b_valid_reg  <= 1'b0;
            bad_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            lit_left_reg <= lit_left_next;
            mlen_reg     <= mlen_next;
            moff_reg     <= moff_next;
            eol_reg      <= eol_next;
            ring_reg     <= ring_next;
            wpos_reg     <= wpos_next;
            rd_left_reg  <= rd_left_next;
            wr_left_reg  <= wr_left_next;
            b_valid_reg  <= b_valid_next;
            bad_reg      <= bad_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        byte_reg    <= byte_next;
        rd_addr_reg <= rd_addr_next;
    end

    // result words carry between one and a full word of bytes
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_count != 4'd0) && (byte_count <= 4'(BYTES_PER_RESULT)))
        else $error("byte_count out of range");

    // reads never run behind the bytes already delivered
    a_copy_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY) |-> (rd_left_reg <= wr_left_reg))
        else $error("copy read count passed write count");

    // a line only ends on the last result of a transaction
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_done |-> run_last)
        else $error("line_done without run_last");

    // a copied byte is pushed only after its history read
    a_push_source: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> (state_reg == ST_LIT) || b_valid_reg)
        else $error("push without data");

endmodule

// File: dv/lz77_line_decoder_tb.sv
// testbench for the lz77 line decoder: directed table, random lines, scoreboard check
module lz77_line_decoder_tb
    import lzd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIRECTED    = 25;
    localparam int RANDOM_ITEMS = 280;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 300;

    // one output transaction
    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  cnt;
        logic        last;
        logic        done;
        logic        bad;
    } decoded_t;

    // one row of the directed table; want is used only when typed is set
    typedef struct packed {
        logic [7:0] code;
        logic       eol;
        logic       typed;
        decoded_t   want;
    } stim_row_t;

    // per input transaction: a fixed expectation, or none to use the predictor
    typedef struct packed {
        logic     typed;
        decoded_t want;
    } byte_note_t;

    localparam decoded_t NO_WORD = '0;

    localparam stim_row_t DIR_ROWS [DIRECTED] = '{
        // first header with top bits set still opens two literals
        '{8'hE1, 1'b0, 1'b0, NO_WORD},
        '{8'h00, 1'b0, 1'b1, '{64'h00, 4'd1, 1'b1, 1'b0, 1'b0}},
        '{8'hFF, 1'b0, 1'b1, '{64'hFF, 4'd1, 1'b1, 1'b0, 1'b0}},
        // short match, distance one
        '{8'h20, 1'b0, 1'b0, NO_WORD},
        '{8'h00, 1'b0, 1'b0, NO_WORD},
        // longest long match, overlapping copy
        '{8'hE0, 1'b0, 1'b0, NO_WORD},
        '{8'hFF, 1'b0, 1'b0, NO_WORD},
        '{8'h04, 1'b0, 1'b0, NO_WORD},
        // largest offset, before line start
        '{8'h3F, 1'b0, 1'b0, NO_WORD},
        '{8'hFF, 1'b0, 1'b1, '{64'h00, 4'd3, 1'b1, 1'b0, 1'b1}},
        '{8'hDF, 1'b0, 1'b0, NO_WORD},
        '{8'hFE, 1'b0, 1'b1, '{64'h00, 4'd8, 1'b1, 1'b0, 1'b1}},
        // literal run closing the line
        '{8'h00, 1'b0, 1'b0, NO_WORD},
        '{8'hA5, 1'b1, 1'b1, '{64'hA5, 4'd1, 1'b1, 1'b1, 1'b0}},
        // match ending a line
        '{8'h00, 1'b0, 1'b0, NO_WORD},
        '{8'h5A, 1'b0, 1'b1, '{64'h5A, 4'd1, 1'b1, 1'b0, 1'b0}},
        '{8'h40, 1'b0, 1'b0, NO_WORD},
        '{8'h00, 1'b1, 1'b0, NO_WORD},
        // line ended on its header, no result
        '{8'h1F, 1'b1, 1'b0, NO_WORD},
        // literal run cut short by end of line
        '{8'h01, 1'b0, 1'b0, NO_WORD},
        '{8'h11, 1'b1, 1'b1, '{64'h11, 4'd1, 1'b1, 1'b1, 1'b0}},
        // long match dropped on its length byte
        '{8'h00, 1'b0, 1'b0, NO_WORD},
        '{8'h77, 1'b0, 1'b1, '{64'h77, 4'd1, 1'b1, 1'b0, 1'b0}},
        '{8'hE0, 1'b0, 1'b0, NO_WORD},
        '{8'h10, 1'b1, 1'b0, NO_WORD}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = 8'h00;
    logic        end_of_line = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        run_last;
    logic        line_done;
    logic        bad_reference;

    // predictor state
    logic [7:0]  hist_mem [HISTORY_BYTES_DEF];
    logic [13:0] hist_wpos;
    logic [12:0] hist_ring;
    phase_t      dec_phase;
    logic [5:0]  lit_left;
    logic [8:0]  copy_len;
    logic [12:0] copy_off;

    decoded_t    step_words [$];
    decoded_t    expected_words [$];
    byte_note_t  sent_notes [$];

    int          failures = 0;
    int          cycles = 0;
    int          items_sent = 0;
    int          quiet_from = DIRECTED + RANDOM_ITEMS - 40;
    int          line_bytes = 0;
    bit          idle_on = 1'b0;

    lz77_line_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .end_of_line   (end_of_line),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_bytes     (out_bytes),
        .byte_count    (byte_count),
        .run_last      (run_last),
        .line_done     (line_done),
        .bad_reference (bad_reference)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("lz77_line_decoder test failed");
            $finish;
        end
    end

    // append one decoded byte to the line history
    task automatic hist_push(input logic [7:0] v);
        hist_mem[hist_ring] = v;
        hist_ring = hist_ring + 13'd1;
        if (hist_wpos < WPOS_MAX)
            hist_wpos = hist_wpos + 14'd1;
    endtask

    task automatic restart_line();
        hist_wpos = '0;
        hist_ring = '0;
        dec_phase = PH_FIRST_HEADER;
        lit_left  = '0;
        copy_len  = '0;
        copy_off  = '0;
    endtask

    // decode one compressed byte, leaving its output transactions in step_words
    task automatic decode_byte(input logic [7:0] b, input logic eol);
        logic [7:0]  run_bytes [$];
        logic [7:0]  v;
        logic        bad;
        logic [2:0]  top;
        int          copy_dist;
        int          n_words;
        int          cnt;
        decoded_t    word;
        step_words = {};
        bad = 1'b0;
        top = b[7:5];
        case (dec_phase)
            PH_FIRST_HEADER:
            begin
                lit_left  = 6'(b[4:0] & LOW5_MASK) + 6'd1;
                dec_phase = PH_LITERAL;
            end
            PH_HEADER:
            begin
                copy_off = 13'(b[4:0] & LOW5_MASK);
                if (top == TOP_LIT)
                begin
                    lit_left  = 6'(b[4:0] & LOW5_MASK) + 6'd1;
                    dec_phase = PH_LITERAL;
                end
                else if (top == TOP_LONG)
                    dec_phase = PH_LONG_LENGTH;
                else
                begin
                    copy_len  = 9'(top) + LEN_BIAS;
                    dec_phase = PH_SHORT_OFFSET;
                end
            end
            PH_LITERAL:
            begin
                run_bytes.push_back(b);
                hist_push(b);
                if (lit_left != 0)
                    lit_left = lit_left - 6'd1;
                if (lit_left == 0)
                    dec_phase = PH_HEADER;
            end
            PH_LONG_LENGTH:
            begin
                copy_len  = 9'(TOP_LONG) + 9'(b) + LEN_BIAS;
                dec_phase = PH_LONG_OFFSET;
            end
            PH_SHORT_OFFSET, PH_LONG_OFFSET:
            begin
                copy_off  = {copy_off[4:0], b};
                copy_dist = int'(copy_off) + 1;
                bad = (copy_dist > int'(hist_wpos)) || (copy_dist > HISTORY_BYTES_DEF);
                // copy runs byte by byte so overlapping sources repeat
                for (int i = 0; i < int'(copy_len); i++)
                begin
                    v = bad ? 8'h00 : hist_mem[13'(int'(hist_ring) - copy_dist)];
                    run_bytes.push_back(v);
                    hist_push(v);
                end
                copy_len  = '0;
                dec_phase = PH_HEADER;
            end
            default:
                dec_phase = PH_HEADER;
        endcase

        // pack into words of up to eight bytes
        n_words = (run_bytes.size() + BYTES_PER_RESULT_DEF - 1) / BYTES_PER_RESULT_DEF;
        for (int k = 0; k < n_words; k++)
        begin
            cnt = run_bytes.size() - k * BYTES_PER_RESULT_DEF;
            if (cnt > BYTES_PER_RESULT_DEF)
                cnt = BYTES_PER_RESULT_DEF;
            word = '0;
            for (int j = 0; j < cnt; j++)
                word.data[8*j +: 8] = run_bytes[k * BYTES_PER_RESULT_DEF + j];
            word.cnt  = 4'(cnt);
            word.last = (k + 1 == n_words);
            word.done = word.last && eol;
            word.bad  = bad;
            step_words.push_back(word);
        end

        if (eol)
            restart_line();
    endtask

    // input side: predict on every accepted transaction
    always @(posedge clk)
    begin
        byte_note_t note;
        if (rst_n && in_valid && !in_stall)
        begin
            note = sent_notes.pop_front();
            decode_byte(in_byte, end_of_line);
            if (note.typed)
                expected_words.push_back(note.want);
            else
                foreach (step_words[i])
                    expected_words.push_back(step_words[i]);
        end
    end

    // output side: compare every accepted transaction with the oldest expectation
    always @(posedge clk)
    begin
        decoded_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected transaction: out_bytes %h byte_count %0d",
                       out_bytes, byte_count);
                failures++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (out_bytes !== want.data)
                begin
                    $error("out_bytes: expected %h, got %h", want.data, out_bytes);
                    failures++;
                end
                if (byte_count !== want.cnt)
                begin
                    $error("byte_count: expected %0d, got %0d", want.cnt, byte_count);
                    failures++;
                end
                if (run_last !== want.last)
                begin
                    $error("run_last: expected %b, got %b", want.last, run_last);
                    failures++;
                end
                if (line_done !== want.done)
                begin
                    $error("line_done: expected %b, got %b", want.done, line_done);
                    failures++;
                end
                if (bad_reference !== want.bad)
                begin
                    $error("bad_reference: expected %b, got %b", want.bad, bad_reference);
                    failures++;
                end
            end
        end
    end

    // output stall bursts
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // drive one byte and wait until it is accepted
    task automatic drive_item(input logic [7:0] b, input logic e, input logic typed,
                              input decoded_t want);
        byte_note_t note;
        idle_on = (items_sent < quiet_from) && ((items_sent / 40) % 4 != 3);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        note.typed = typed;
        note.want  = want;
        sent_notes.push_back(note);
        in_valid    <= 1'b1;
        in_byte     <= b;
        end_of_line <= e;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // random byte; unless clean, a rare stray end of line cuts the line short
    task automatic send_byte(input logic [7:0] b, input logic close, input logic clean,
                             inout logic ended);
        logic e;
        e = close || (!clean && $urandom_range(0, 59) == 0);
        drive_item(b, e, 1'b0, NO_WORD);
        if (e)
            ended = 1'b1;
    endtask

    task automatic count_bytes(input int n);
        line_bytes = line_bytes + n;
        if (line_bytes > int'(WPOS_MAX))
            line_bytes = int'(WPOS_MAX);
    endtask

    // literal header and its run, mostly short
    task automatic lit_token(input logic first, input logic clean, input logic close,
                             inout logic ended);
        logic [4:0] low;
        logic [2:0] top;
        low = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                          : 5'($urandom_range(0, 5));
        top = (first && $urandom_range(0, 2) == 0) ? 3'($urandom_range(1, 7)) : TOP_LIT;
        send_byte({top, low}, 1'b0, clean, ended);
        for (int i = 0; i <= int'(low) && !ended; i++)
        begin
            send_byte(8'($urandom), close && (i == int'(low)), clean, ended);
            count_bytes(1);
        end
    endtask

    // short or long match, mostly reaching back inside the line
    task automatic match_token(input logic is_long, input logic full_len, input logic clean,
                               input logic close, inout logic ended);
        int          reach;
        int          len;
        logic [12:0] off;
        logic [2:0]  top;
        logic [7:0]  lbyte;
        reach = (line_bytes < HISTORY_BYTES_DEF) ? line_bytes : HISTORY_BYTES_DEF;
        if (reach == 0 || (!clean && $urandom_range(0, 7) == 0))
        begin
            if (reach >= HISTORY_BYTES_DEF)
                off = 13'($urandom_range(0, reach - 1));
            else
                off = 13'($urandom_range(reach, HISTORY_BYTES_DEF - 1));
        end
        else if ($urandom_range(0, 1) == 0)
            off = 13'($urandom_range(0, ((reach < 8) ? reach : 8) - 1));
        else
            off = 13'($urandom_range(0, reach - 1));

        lbyte = 8'h00;
        if (is_long)
        begin
            top = TOP_LONG;
            if (full_len)
                lbyte = 8'hFF;
            else if ($urandom_range(0, 7) == 0)
                lbyte = 8'($urandom);
            else
                lbyte = 8'($urandom_range(0, 20));
            len = int'(TOP_LONG) + int'(lbyte) + int'(LEN_BIAS);
        end
        else
        begin
            top = 3'($urandom_range(1, 6));
            len = int'(top) + int'(LEN_BIAS);
        end

        send_byte({top, off[12:8]}, 1'b0, clean, ended);
        if (is_long && !ended)
            send_byte(lbyte, 1'b0, clean, ended);
        if (!ended)
        begin
            send_byte(off[7:0], close, clean, ended);
            count_bytes(len);
        end
    endtask

    // well-formed line with random content; heavy lines wrap the history
    task automatic random_line(input logic heavy);
        logic ended;
        logic close;
        int   tokens;
        ended = 1'b0;
        line_bytes = 0;
        tokens = heavy ? 63 : $urandom_range(0, 6);
        lit_token(1'b1, heavy, tokens == 0, ended);
        for (int k = 0; k < tokens && !ended; k++)
        begin
            close = (k + 1 == tokens);
            if (heavy)
                match_token(1'b1, 1'b1, 1'b1, close, ended);
            else
                case ($urandom_range(0, 2))
                    0: lit_token(1'b0, 1'b0, close, ended);
                    1: match_token(1'b0, 1'b0, 1'b0, close, ended);
                    default: match_token(1'b1, 1'b0, 1'b0, close, ended);
                endcase
        end
    endtask

    // line of raw random bytes
    task automatic noise_line();
        logic ended;
        int   n;
        ended = 1'b0;
        n = $urandom_range(1, 10);
        for (int i = 0; i < n && !ended; i++)
            send_byte(8'($urandom), i == n - 1, 1'b0, ended);
    endtask

    // reset, stimulus, drain and verdict
    initial
    begin
        logic heavy_done;
        restart_line();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < DIRECTED; r++)
            drive_item(DIR_ROWS[r].code, DIR_ROWS[r].eol, DIR_ROWS[r].typed,
                       DIR_ROWS[r].want);

        // random lines
        heavy_done = 1'b0;
        while (items_sent < DIRECTED + RANDOM_ITEMS)
        begin
            if (!heavy_done && items_sent > DIRECTED + 80)
            begin
                random_line(1'b1);
                heavy_done = 1'b1;
            end
            else if ($urandom_range(0, 7) == 0)
                noise_line();
            else
                random_line(1'b0);
        end

        in_valid <= 1'b0;
        idle_on = 1'b0;
        while (expected_words.size() != 0 || sent_notes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("lz77_line_decoder test passed");
        else
            $display("lz77_line_decoder test failed");
        $finish;
    end

endmodule
